### rtl/detection_proposal_decoder_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the detection proposal decoder
// Shared property forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef DETECTION_PROPOSAL_DECODER_UNIT_ASSERT_SVH
`define DETECTION_PROPOSAL_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, masked while reset is held.
`define DPD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dpd check failed");

// Next-cycle implication, masked while reset is held.
`define DPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dpd check failed");

// Next-cycle implication that is also checked across reset.
`define DPD_ASSERT_ALWAYS_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("dpd check failed");

`endif

### rtl/dpd_pkg.sv
// ---------------------------------------------------------------------------
// dpd_pkg
// Types and constants shared by the detection proposal decoder modules.
// ---------------------------------------------------------------------------
`default_nettype none

package dpd_pkg;

  // Item kind carried on in_tuser
  localparam logic FUNC_HEADER = 1'b0;
  localparam logic FUNC_CLASS  = 1'b1;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH     = 2'd0,
    CFG_IMAGE_HEIGHT    = 2'd1,
    CFG_SCORE_THRESHOLD = 2'd2
  } cfg_idx_t;

  localparam logic [12:0] IMAGE_WIDTH_RST     = 13'd640;
  localparam logic [12:0] IMAGE_HEIGHT_RST    = 13'd640;
  localparam logic [16:0] SCORE_THRESHOLD_RST = 17'd16384;

  // Largest image dimension honored by the box math
  localparam logic [12:0] DIM_MAX = 13'd4096;

  // Joint score saturation (1.0 in Q1.16)
  localparam logic [17:0] JOINT_MAX = 18'h10000;

  // Proposal queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;

  // One surviving proposal handed from front to back
  typedef struct packed {
    logic [16:0]        score;
    logic signed [6:0]  cls_idx;
    logic [16:0]        center_x;
    logic [16:0]        center_y;
    logic [16:0]        box_w;
    logic [16:0]        box_h;
  } prop_t;

  // Queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

### rtl/detection_proposal_decoder_unit.sv
// ---------------------------------------------------------------------------
// detection_proposal_decoder_unit
// Decodes one detection proposal per header plus class-score run.
// ---------------------------------------------------------------------------
// Usage:
//   in_*   : a header item (in_tuser = 0) carries box centre, size and
//            objectness; each class item (in_tuser = 1) carries one class
//            score, in_tlast marks the proposal's final class.
//   out_*  : one box per proposal whose best joint score reaches the
//            threshold and whose clamped box has positive width and height.
//   cfg_*  : image width, image height and score threshold; write only while
//            no item is in flight.
// Throughput: one input item per cycle while the queue takes proposals.
// Path: once its last class item is accepted, a box goes through the score
//   stage, the queue, the box multiply stage and the output register.
// The running best score loop is one multiply stage plus one compare stage
// per item; the box math is one multiply stage plus one add/compare stage.
// Reset: config returns to 640 x 640 and threshold 0.25; held box, best
//   score and class count clear, the queue and output empty.
// Receiver stall: the output register holds; up to four proposals wait in
//   the queue, after which in_tready drops while a finished proposal waits.
// ---------------------------------------------------------------------------
`default_nettype none

module detection_proposal_decoder_unit #(
  parameter int MAX_CLASSES = 64
) (
  input  wire          clk,
  input  wire          rst_n,
  // in_tdata: center_x[16:0], center_y[33:17], box_w[50:34], box_h[67:51],
  //           objectness[84:68], class_score[101:85], zero pad [103:102]
  input  wire  [103:0] in_tdata,
  // in_tuser: func (0 header, 1 class score)
  input  wire          in_tuser,
  input  wire          in_tlast,
  input  wire          in_tvalid,
  output logic         in_tready,
  // out_tdata: left[16:0], top[33:17], width_px[50:34], height_px[67:51],
  //            cls_idx[74:68], confidence[91:75], zero pad [95:92]
  output logic [95:0]  out_tdata,
  output logic         out_tvalid,
  input  wire          out_tready,
  input  wire          cfg_we,
  input  wire  [1:0]   cfg_index,
  input  wire  [16:0]  cfg_wdata
);

  // Configuration registers
  logic [12:0] image_width_r;
  logic [12:0] image_height_r;
  logic [16:0] score_threshold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r     <= dpd_pkg::IMAGE_WIDTH_RST;
      image_height_r    <= dpd_pkg::IMAGE_HEIGHT_RST;
      score_threshold_r <= dpd_pkg::SCORE_THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dpd_pkg::CFG_IMAGE_WIDTH:     image_width_r     <= cfg_wdata[12:0];
        dpd_pkg::CFG_IMAGE_HEIGHT:    image_height_r    <= cfg_wdata[12:0];
        dpd_pkg::CFG_SCORE_THRESHOLD: score_threshold_r <= cfg_wdata;
        default: ; // unused index, write dropped
      endcase
    end
  end

  dpd_pkg::prop_t     push_data, head;
  dpd_pkg::q_status_t q_stat;
  logic               push, pop;

  logic [16:0]        o_left, o_top, o_w, o_h, o_conf;
  logic signed [6:0]  o_cls;

  // Front: running best joint score per proposal, threshold check
  dpd_front #(
    .MAX_CLASSES (MAX_CLASSES)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_tvalid),
    .in_ready        (in_tready),
    .func            (in_tuser),
    .center_x        (in_tdata[16:0]),
    .center_y        (in_tdata[33:17]),
    .box_w           (in_tdata[50:34]),
    .box_h           (in_tdata[67:51]),
    .objectness      (in_tdata[84:68]),
    .class_score     (in_tdata[101:85]),
    .last_class      (in_tlast),
    .score_threshold (score_threshold_r),
    .q_stat          (q_stat),
    .push            (push),
    .prop            (push_data)
  );

  // Proposals waiting for box conversion
  dpd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  // Back: corner form, clamping, size limit, output register
  dpd_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (head),
    .q_stat       (q_stat),
    .pop          (pop),
    .image_width  (image_width_r),
    .image_height (image_height_r),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .left         (o_left),
    .top          (o_top),
    .width_px     (o_w),
    .height_px    (o_h),
    .cls_idx      (o_cls),
    .confidence   (o_conf)
  );

  assign out_tdata = {4'b0000, o_conf, o_cls, o_h, o_w, o_top, o_left};

endmodule

`default_nettype wire

### rtl/dpd_front.sv
// ---------------------------------------------------------------------------
// dpd_front
// Takes header and class items, tracks the best joint score per proposal
// and pushes proposals that pass the threshold into the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module dpd_front #(
  parameter int MAX_CLASSES = 64
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire                 func,
  input  wire  [16:0]         center_x,
  input  wire  [16:0]         center_y,
  input  wire  [16:0]         box_w,
  input  wire  [16:0]         box_h,
  input  wire  [16:0]         objectness,
  input  wire  [16:0]         class_score,
  input  wire                 last_class,
  input  wire  [16:0]         score_threshold,
  input  dpd_pkg::q_status_t  q_stat,
  output logic                push,
  output dpd_pkg::prop_t      prop
);

  localparam int CNT_W = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_CLASSES - 1);

  // accept side
  logic [CNT_W-1:0] cnt_r;
  logic             full_r;
  logic [16:0]      obj_r;

  // score stage
  logic             b_valid_r;
  logic             b_func_r;
  logic             b_last_r;
  logic             b_take_r;
  logic [CNT_W-1:0] b_idx_r;
  logic [33:0]      b_prod_r;
  logic [16:0]      b_cx_r, b_cy_r, b_w_r, b_h_r;

  // proposal state
  logic [16:0]       held_cx_r, held_cy_r, held_w_r, held_h_r;
  logic [16:0]       best_r;
  logic signed [6:0] best_cls_r;

  logic              en, acc, is_cls, upd;
  logic [17:0]       joint_raw;
  logic [16:0]       joint;
  logic [16:0]       best_nxt;
  logic signed [6:0] best_cls_nxt;
  logic [6:0]        idx_ext;

  // Stall only while a finished proposal waits on a full queue
  assign en       = !(b_valid_r && (b_func_r == dpd_pkg::FUNC_CLASS) && b_last_r
                      && q_stat.full);
  assign in_ready = en;
  assign acc      = in_valid && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      full_r <= 1'b0;
      obj_r  <= '0;
    end else if (acc) begin
      if (func == dpd_pkg::FUNC_HEADER) begin
        cnt_r  <= '0;
        full_r <= 1'b0;
        obj_r  <= objectness;
      end else if (last_class) begin
        cnt_r  <= '0;
        full_r <= 1'b0;
      end else if (!full_r) begin
        if (cnt_r == CNT_LAST) begin
          cnt_r  <= '0;
          full_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (en) begin
      b_valid_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      b_func_r <= func;
      b_last_r <= last_class;
      b_take_r <= !full_r;
      b_idx_r  <= cnt_r;
      b_prod_r <= obj_r * class_score;
      b_cx_r   <= center_x;
      b_cy_r   <= center_y;
      b_w_r    <= box_w;
      b_h_r    <= box_h;
    end
  end

  // joint = obj * score >> 16, saturated at 1.0
  assign joint_raw = b_prod_r[33:16];
  assign joint     = (joint_raw > dpd_pkg::JOINT_MAX) ? dpd_pkg::JOINT_MAX[16:0]
                                                      : joint_raw[16:0];
  assign idx_ext   = {{(7 - CNT_W){1'b0}}, b_idx_r};
  assign is_cls    = b_valid_r && (b_func_r == dpd_pkg::FUNC_CLASS);
  assign upd       = b_take_r && (joint > best_r);
  assign best_nxt     = upd ? joint : best_r;
  assign best_cls_nxt = upd ? $signed(idx_ext) : best_cls_r;

  assign push = en && is_cls && b_last_r && (best_nxt >= score_threshold);

  always_comb begin
    prop.score    = best_nxt;
    prop.cls_idx  = best_cls_nxt;
    prop.center_x = held_cx_r;
    prop.center_y = held_cy_r;
    prop.box_w    = held_w_r;
    prop.box_h    = held_h_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_cx_r  <= '0;
      held_cy_r  <= '0;
      held_w_r   <= '0;
      held_h_r   <= '0;
      best_r     <= '0;
      best_cls_r <= -7'sd1;
    end else if (en && b_valid_r) begin
      if (b_func_r == dpd_pkg::FUNC_HEADER) begin
        held_cx_r  <= b_cx_r;
        held_cy_r  <= b_cy_r;
        held_w_r   <= b_w_r;
        held_h_r   <= b_h_r;
        best_r     <= '0;
        best_cls_r <= -7'sd1;
      end else if (b_last_r) begin
        best_r     <= '0;
        best_cls_r <= -7'sd1;
      end else begin
        best_r     <= best_nxt;
        best_cls_r <= best_cls_nxt;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/dpd_queue.sv
// ---------------------------------------------------------------------------
// dpd_queue
// Short register FIFO of proposals between front and back.
// ---------------------------------------------------------------------------
`default_nettype none

module dpd_queue (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  dpd_pkg::prop_t      push_data,
  input  wire                 pop,
  output dpd_pkg::prop_t      head,
  output dpd_pkg::q_status_t  stat
);

  dpd_pkg::prop_t                 mem_r [dpd_pkg::Q_DEPTH];
  logic [dpd_pkg::Q_PTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [dpd_pkg::Q_PTR_W:0]      cnt_r;
  logic                           do_push, do_pop;

  assign stat.full  = (cnt_r == (dpd_pkg::Q_PTR_W + 1)'(dpd_pkg::Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/dpd_back.sv
// ---------------------------------------------------------------------------
// dpd_back
// Turns queued proposals into clamped corner boxes and drives the result
// register.
// ---------------------------------------------------------------------------
`default_nettype none

module dpd_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  dpd_pkg::prop_t      head,
  input  dpd_pkg::q_status_t  q_stat,
  output logic                pop,
  input  wire  [12:0]         image_width,
  input  wire  [12:0]         image_height,
  output logic                out_valid,
  input  wire                 out_ready,
  output logic [16:0]         left,
  output logic [16:0]         top,
  output logic [16:0]         width_px,
  output logic [16:0]         height_px,
  output logic signed [6:0]   cls_idx,
  output logic [16:0]         confidence
);

  typedef struct packed {
    logic        keep;
    logic [16:0] corner;
    logic [16:0] extent;
  } axis_t;

  // corner = max(0, d*dim) >> 13, extent = min(size*dim >> 12, 16*dim - corner)
  function automatic axis_t place(input logic pos_ok, input logic [29:0] pd,
                                  input logic [28:0] ps, input logic [12:0] dim);
    axis_t              r;
    logic [16:0]        ext;
    logic signed [17:0] room;
    r.corner = pos_ok ? pd[29:13] : '0;
    ext      = ps[28:12];
    room     = $signed({1'b0, dim, 4'b0000}) - $signed({1'b0, r.corner});
    if ($signed({1'b0, ext}) > room) begin
      r.extent = room[16:0];
      r.keep   = (room > 18'sd0);
    end else begin
      r.extent = ext;
      r.keep   = (ext != '0);
    end
    return r;
  endfunction

  logic               adv;
  logic [12:0]        dim_x, dim_y;
  logic signed [18:0] dx, dy;
  logic [30:0]        pdx, pdy;
  logic [29:0]        pw, ph;

  logic               s1_valid_r;
  logic               s1_xpos_r, s1_ypos_r;
  logic [29:0]        s1_pdx_r, s1_pdy_r;
  logic [28:0]        s1_pw_r, s1_ph_r;
  logic [12:0]        s1_dimx_r, s1_dimy_r;
  logic [16:0]        s1_score_r;
  logic signed [6:0]  s1_cls_r;

  axis_t              ax, ay;
  logic               out_valid_r;

  assign adv = !out_valid_r || out_ready;
  assign pop = adv && !q_stat.empty;

  assign dim_x = (image_width  > dpd_pkg::DIM_MAX) ? dpd_pkg::DIM_MAX : image_width;
  assign dim_y = (image_height > dpd_pkg::DIM_MAX) ? dpd_pkg::DIM_MAX : image_height;
  assign dx    = $signed({1'b0, head.center_x, 1'b0}) - $signed({2'b00, head.box_w});
  assign dy    = $signed({1'b0, head.center_y, 1'b0}) - $signed({2'b00, head.box_h});
  assign pdx   = dx[17:0] * dim_x;
  assign pdy   = dy[17:0] * dim_y;
  assign pw    = head.box_w * dim_x;
  assign ph    = head.box_h * dim_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= !q_stat.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_xpos_r  <= !dx[18] && (dx != '0);
      s1_ypos_r  <= !dy[18] && (dy != '0);
      s1_pdx_r   <= pdx[29:0];
      s1_pdy_r   <= pdy[29:0];
      s1_pw_r    <= pw[28:0];
      s1_ph_r    <= ph[28:0];
      s1_dimx_r  <= dim_x;
      s1_dimy_r  <= dim_y;
      s1_score_r <= head.score;
      s1_cls_r   <= head.cls_idx;
    end
  end

  assign ax = place(s1_xpos_r, s1_pdx_r, s1_pw_r, s1_dimx_r);
  assign ay = place(s1_ypos_r, s1_pdy_r, s1_ph_r, s1_dimy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r && ax.keep && ay.keep;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      left       <= ax.corner;
      top        <= ay.corner;
      width_px   <= ax.extent;
      height_px  <= ay.extent;
      cls_idx    <= s1_cls_r;
      confidence <= s1_score_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

### rtl/dpd_checker.sv
// ---------------------------------------------------------------------------
// dpd_checker
// Port-level checks on the detection proposal decoder, bound to the top.
// ---------------------------------------------------------------------------
`default_nettype none

`include "detection_proposal_decoder_unit_assert.svh"

module dpd_checker (
  input wire          clk,
  input wire          rst_n,
  input wire  [95:0]  out_tdata,
  input wire          out_tvalid,
  input wire          out_tready
);

  // result holds while the receiver stalls
  `DPD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // emitted boxes always have a positive size
  `DPD_ASSERT_NOW(a_size_pos, out_tvalid, (out_tdata[50:34] != 17'd0) && (out_tdata[67:51] != 17'd0))

  // no winning class means the best joint score stayed at zero
  `DPD_ASSERT_NOW(a_no_class, out_tvalid && (out_tdata[74:68] == 7'h7F), out_tdata[91:75] == 17'd0)

  // reset empties the result register
  `DPD_ASSERT_ALWAYS_NEXT(a_rst_empty, !rst_n, !out_tvalid)

endmodule

bind detection_proposal_decoder_unit dpd_checker u_dpd_checker (.*);

`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench for detection_proposal_decoder_unit
// Streams header and class-score items through the decoder, predicts every
// box from its own copy of the proposal state and compares the boxes that
// come out field by field. The run steps through several image sizes and
// thresholds, the extremes included, with random gaps on both sides outside one burst phase.
// ---------------------------------------------------------------------------
module testbench;

  localparam int CLASS_LIMIT = 64;      // MAX_CLASSES of the block
  localparam int GAP_PCT     = 37;      // idle cycles per hundred, each side
  localparam int DRAIN_WAIT  = 12;      // covers the score, queue, box and output stages
  localparam int CYCLE_LIMIT = 300000;

  // one item waiting for the driver
  typedef struct {
    logic         func;
    logic         last;
    logic [103:0] data;
  } stream_item_t;

  // one decoded box, laid out as on out_tdata (left in the low bits)
  typedef struct packed {
    logic [16:0]       confidence;
    logic signed [6:0] cls_idx;
    logic [16:0]       height_px;
    logic [16:0]       width_px;
    logic [16:0]       top;
    logic [16:0]       left;
  } box_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic [103:0] in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         in_tlast = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [95:0]  out_tdata;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [16:0]  cfg_wdata = '0;

  stream_item_t pending_items[$];
  box_t         expected_boxes[$];
  int           error_count = 0;
  int           cycle_count = 0;
  bit           burst_mode = 1'b0;   // no gaps on either side while set

  // predictor copy of the configuration
  logic [12:0]  img_w = dpd_pkg::IMAGE_WIDTH_RST;
  logic [12:0]  img_h = dpd_pkg::IMAGE_HEIGHT_RST;
  logic [16:0]  min_score = dpd_pkg::SCORE_THRESHOLD_RST;

  // predictor copy of the proposal state
  logic [16:0]       box_cx = '0;
  logic [16:0]       box_cy = '0;
  logic [16:0]       box_w_q = '0;
  logic [16:0]       box_h_q = '0;
  logic [16:0]       box_obj = '0;
  logic [16:0]       run_best = '0;
  logic signed [6:0] run_class = -7'sd1;
  int                run_count = 0;
  bit                run_full = 1'b0;

  detection_proposal_decoder_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Box math: corner in 1/16 px clamped at zero, extent limited to the
  // image edge. Returns 0 when the extent is not positive.
  // ---------------------------------------------------------------------
  function automatic bit place_edge(input longint centre, input longint size,
                                    input longint dim,
                                    output logic [16:0] corner,
                                    output logic [16:0] extent);
    longint d;
    longint pos;
    longint ext;
    longint room;
    if (dim > 4096) dim = 4096;
    d = 2 * centre - size;
    pos = (d > 0) ? ((d * dim) >>> 13) : 0;
    ext = (size * dim) >>> 12;
    room = 16 * dim - pos;
    if (ext > room) ext = room;
    corner = pos[16:0];
    extent = ext[16:0];
    return ext > 0;
  endfunction

  task automatic restart_run();
    run_best = '0;
    run_class = -7'sd1;
    run_count = 0;
    run_full = 1'b0;
  endtask

  // Advances the proposal state by one accepted item, queues a box if due.
  task automatic decode_proposal_item(input logic func, input logic [103:0] data,
                                      input logic last);
    longint joint;
    box_t   box;
    bit     keep;
    if (func == dpd_pkg::FUNC_HEADER) begin
      // header: latch box and objectness, last flag ignored
      box_cx  = data[16:0];
      box_cy  = data[33:17];
      box_w_q = data[50:34];
      box_h_q = data[67:51];
      box_obj = data[84:68];
      restart_run();
      return;
    end
    // scores past the class limit are not compared
    if (!run_full) begin
      joint = (longint'(box_obj) * longint'(data[101:85])) >>> 16;
      if (joint > 65536) joint = 65536;
      if (joint[16:0] > run_best) begin
        run_best = joint[16:0];
        run_class = 7'(run_count);
      end
      run_count++;
      if (run_count >= CLASS_LIMIT) begin
        run_count = 0;
        run_full = 1'b1;
      end
    end
    if (!last) return;
    keep = run_best >= min_score;
    if (keep) keep = place_edge(box_cx, box_w_q, img_w, box.left, box.width_px);
    if (keep) keep = place_edge(box_cy, box_h_q, img_h, box.top, box.height_px);
    if (keep) begin
      box.cls_idx = run_class;
      box.confidence = run_best;
      expected_boxes = {expected_boxes, box};
    end
    // held box stays for a following class run without header
    restart_run();
  endtask

  // ---------------------------------------------------------------------
  // Driver: presents queued items, random gaps unless in burst mode.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : drive
    stream_item_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_items.size() != 0 &&
          (burst_mode || $urandom_range(99) >= GAP_PCT)) begin
        nxt = pending_items.pop_front();
        in_tdata  <= nxt.data;
        in_tuser  <= nxt.func;
        in_tlast  <= nxt.last;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= burst_mode || ($urandom_range(99) >= GAP_PCT);
  end

  // ---------------------------------------------------------------------
  // Monitor: predict on every accepted input item, check every box.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : watch
    box_t got;
    box_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) decode_proposal_item(in_tuser, in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        got = out_tdata[91:0];
        if (expected_boxes.size() == 0) begin
          $error("box with none expected: %h", out_tdata);
          error_count++;
        end else begin
          want = expected_boxes.pop_front();
          if (got.left !== want.left) begin
            $error("left: expected %0d, got %0d", want.left, got.left);
            error_count++;
          end
          if (got.top !== want.top) begin
            $error("top: expected %0d, got %0d", want.top, got.top);
            error_count++;
          end
          if (got.width_px !== want.width_px) begin
            $error("width_px: expected %0d, got %0d", want.width_px, got.width_px);
            error_count++;
          end
          if (got.height_px !== want.height_px) begin
            $error("height_px: expected %0d, got %0d", want.height_px, got.height_px);
            error_count++;
          end
          if (got.cls_idx !== want.cls_idx) begin
            $error("cls_idx: expected %0d, got %0d", want.cls_idx, got.cls_idx);
            error_count++;
          end
          if (got.confidence !== want.confidence) begin
            $error("confidence: expected %0d, got %0d", want.confidence, got.confidence);
            error_count++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  task automatic push_header(input logic [16:0] cx, input logic [16:0] cy,
                             input logic [16:0] w, input logic [16:0] h,
                             input logic [16:0] obj, input logic last);
    stream_item_t it;
    logic [16:0]  junk;
    junk = 17'($urandom);   // class_score is ignored on a header
    it.func = dpd_pkg::FUNC_HEADER;
    it.last = last;
    it.data = {2'b00, junk, obj, h, w, cy, cx};
    pending_items = {pending_items, it};
  endtask

  task automatic push_class(input logic [16:0] score, input logic last);
    stream_item_t it;
    logic [84:0]  junk;
    // box fields are ignored on a class item
    junk = {21'($urandom), 32'($urandom), 32'($urandom)};
    it.func = dpd_pkg::FUNC_CLASS;
    it.last = last;
    it.data = {2'b00, score, junk};
    pending_items = {pending_items, it};
  endtask

  // Q1.16 value: mostly in range, with extremes and full 17-bit values
  function automatic logic [16:0] rand_q16();
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) return 17'd0;
    if (pick < 16) return 17'h10000;
    if (pick < 24) return 17'($urandom);
    return 17'($urandom_range(65536, 0));
  endfunction

  task automatic add_random_proposal();
    int          pick;
    int          n_cls;
    logic [16:0] obj;
    logic [16:0] score;
    pick = $urandom_range(99);
    if (pick < 6) begin
      // noise: lone item of either kind
      if ($urandom_range(1)) push_class(rand_q16(), 1'($urandom));
      else push_header(rand_q16(), rand_q16(), rand_q16(), rand_q16(), rand_q16(),
                       1'($urandom));
      return;
    end
    if (pick >= 12) begin
      obj = ($urandom_range(99) < 70) ? 17'($urandom_range(65536, 20000)) : rand_q16();
      push_header(rand_q16(), rand_q16(), 17'($urandom_range(40000, 0)) | rand_q16() & 17'h0,
                  17'($urandom_range(40000, 0)), obj, 1'($urandom));
      if ($urandom_range(9) == 0) begin
        // odd-size boxes now and then
        pending_items[$].data[67:34] = {rand_q16(), rand_q16()};
      end
    end
    // class run; below 12 it reuses the held box without a new header
    pick = $urandom_range(99);
    if (pick < 5) n_cls = $urandom_range(70, 60);   // near and past the class limit
    else if (pick < 20) n_cls = $urandom_range(20, 9);
    else n_cls = $urandom_range(8, 1);
    for (int i = 0; i < n_cls; i++) begin
      score = ($urandom_range(99) < 15) ? 17'd0 : rand_q16();
      push_class(score, i == n_cls - 1);
    end
  endtask

  task automatic run_random(input int n_items);
    int target;
    target = pending_items.size() + n_items;
    while (pending_items.size() < target) add_random_proposal();
  endtask

  // wait for everything to drain, then let dropped proposals leave the pipe
  task automatic drain();
    while (pending_items.size() != 0 || in_tvalid || expected_boxes.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic program_setup(input logic [12:0] w, input logic [12:0] h,
                               input logic [16:0] thr);
    cfg_we <= 1'b1;
    cfg_index <= dpd_pkg::CFG_IMAGE_WIDTH;
    cfg_wdata <= {4'd0, w};
    @(posedge clk);
    cfg_index <= dpd_pkg::CFG_IMAGE_HEIGHT;
    cfg_wdata <= {4'd0, h};
    @(posedge clk);
    cfg_index <= dpd_pkg::CFG_SCORE_THRESHOLD;
    cfg_wdata <= thr;
    @(posedge clk);
    cfg_we <= 1'b0;
    img_w = w;
    img_h = h;
    min_score = thr;
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset config 640 x 640, threshold 0.25
    push_class(17'd65535, 1'b1);                 // before any header: zero box
    push_header(17'd32768, 17'd32768, 17'h10000, 17'h10000, 17'h10000, 1'b1);
    push_class(17'd0, 1'b0);
    push_class(17'h10000, 1'b0);
    push_class(17'h10000, 1'b1);                 // tie keeps the first
    push_class(17'd40000, 1'b1);                 // new run on the held box
    push_header(17'd0, 17'd0, 17'h10000, 17'd32768, 17'd50000, 1'b0);
    push_class(17'h10000, 1'b1);                 // corner clamped at zero
    push_header(17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 1'b0);
    push_class(17'h1FFFF, 1'b1);                 // saturated joint, off image
    push_header(17'd30000, 17'd30000, 17'd0, 17'd20000, 17'h10000, 1'b0);
    push_class(17'h10000, 1'b1);                 // zero width, dropped
    push_header(17'h10000, 17'h10000, 17'd100, 17'd100, 17'h10000, 1'b0);
    push_class(17'h10000, 1'b1);                 // extent cut at the image edge
    push_class(17'd0, 1'b0);
    push_class(17'd0, 1'b1);                     // all zero scores, dropped
    push_header(17'd20000, 17'd40000, 17'd8000, 17'd9000, 17'd16384, 1'b0);
    push_class(17'h10000, 1'b1);                 // exactly at threshold
    push_header(17'd20000, 17'd40000, 17'd8000, 17'd9000, 17'd16383, 1'b0);
    push_class(17'h10000, 1'b1);                 // just below threshold
    run_random(150);
    drain();

    // smallest image, threshold zero: class -1 boxes pass
    program_setup(13'd1, 13'd4096, 17'd0);
    run_random(120);
    drain();

    // largest image, threshold 1.0
    program_setup(13'd4096, 13'd1, 17'h10000);
    run_random(80);
    drain();

    // oversized dimensions act as 4096; no gaps anywhere here
    burst_mode = 1'b1;
    program_setup(13'h1FFF, 13'd5000, 17'd20000);
    run_random(150);
    drain();
    burst_mode = 1'b0;

    // zero width and threshold above 1.0: nothing survives
    program_setup(13'd0, 13'd640, 17'h1FFFF);
    run_random(30);
    drain();

    program_setup(13'($urandom_range(4096, 1)), 13'($urandom_range(4096, 1)),
                  17'($urandom_range(40000, 0)));
    run_random(100);
    drain();

    if (error_count == 0 && expected_boxes.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### detection_proposal_decoder_unit.f
+incdir+rtl
rtl/dpd_pkg.sv
rtl/dpd_front.sv
rtl/dpd_queue.sv
rtl/dpd_back.sv
rtl/detection_proposal_decoder_unit.sv
rtl/dpd_checker.sv
dv/testbench.sv
